[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define PMSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define PMSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pmsd_pkg.sv]
// package: constants and types for the pwm motor speed and direction block
package pmsd_pkg;

    localparam int unsigned PERIOD = 100;

    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned TICKS_W = 8;
    localparam int unsigned CFG_W   = 8;

    localparam logic [DUTY_W-1:0]  DUTY_RESET = DUTY_W'(50);
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(5);
    localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(10);

    localparam logic CFG_DUTY_STEP      = 1'b0;
    localparam logic CFG_DEBOUNCE_TICKS = 1'b1;

    typedef struct packed {
        logic up_n;
        logic down_n;
        logic reverse_n;
    } t_keys;

    typedef struct packed {
        logic turn;
        logic up;
        logic down;
    } t_key_cmd;

endpackage

[sv/pmsd_ifs.sv]
// interfaces: key tick input channel and pwm result channel
interface pmsd_in_if;
    logic valid;
    logic ready;
    logic key_up_n;
    logic key_down_n;
    logic key_reverse_n;

    modport source (output valid, output key_up_n, output key_down_n,
                    output key_reverse_n, input ready);
    modport sink (input valid, input key_up_n, input key_down_n,
                  input key_reverse_n, output ready);
endinterface

interface pmsd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            drive_forward;
    logic                            drive_reverse;
    logic [pmsd_pkg::DUTY_W-1:0]     duty_now;
    logic                            forward_now;

    modport source (output valid, output drive_forward, output drive_reverse,
                    output duty_now, output forward_now, input ready);
    modport sink (input valid, input drive_forward, input drive_reverse,
                  input duty_now, input forward_now, output ready);
endinterface

[sv/pmsd_debounce.sv]
// shared key debounce sequencer: turn, then increase, then decrease
module pmsd_debounce (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  pmsd_pkg::t_keys                  i_keys,
    input  logic [pmsd_pkg::TICKS_W-1:0]     i_debounce_ticks,
    output pmsd_pkg::t_key_cmd               o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_RELEASE
    } t_state;

    typedef enum logic [1:0] {
        KEY_NONE,
        KEY_REV,
        KEY_UP,
        KEY_DOWN
    } t_key;

    t_state                        r_state, n_state;
    t_key                          r_key, n_key;
    logic [pmsd_pkg::TICKS_W-1:0]  r_count, n_count;
    logic [pmsd_pkg::TICKS_W-1:0]  count_dec;
    logic                          key_held;

    always_comb begin
        unique case (r_key)
            KEY_REV:  key_held = !i_keys.reverse_n;
            KEY_UP:   key_held = !i_keys.up_n;
            KEY_DOWN: key_held = !i_keys.down_n;
            default:  key_held = 1'b0;
        endcase
    end

    assign count_dec = (r_count != '0) ? r_count - 1'b1 : r_count;

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_count = r_count;
        o_cmd   = '0;
        unique case (r_state)
            ST_WAIT: begin
                n_count = count_dec;
                if (count_dec == '0) begin
                    if (key_held) begin
                        o_cmd.turn = (r_key == KEY_REV);
                        o_cmd.up   = (r_key == KEY_UP);
                        o_cmd.down = (r_key == KEY_DOWN);
                    end
                    n_state = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                if (!key_held) begin
                    n_state = ST_IDLE;
                    n_key   = KEY_NONE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                priority if (!i_keys.reverse_n) begin
                    n_key = KEY_REV;
                end else if (!i_keys.up_n) begin
                    n_key = KEY_UP;
                end else if (!i_keys.down_n) begin
                    n_key = KEY_DOWN;
                end else begin
                    n_key = KEY_NONE;
                end
                if (n_key != KEY_NONE) begin
                    n_count = i_debounce_ticks;
                    n_state = ST_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_key   <= KEY_NONE;
            r_count <= '0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_key   <= n_key;
            r_count <= n_count;
        end
    end

endmodule

[sv/pwm_motor_speed_direction_top.sv]
// top level: pwm motor speed and direction control, one result per tick
// the result is registered: it appears on the output channel in the cycle after its tick is accepted
// throughput: one tick per cycle while the output channel is not stalled, set by the
//   single registered update of duty, direction, phase and debounce state
// reset: synchronous, active low; duty 50, forward, phase 0, sequencer idle,
//   duty_step 5, debounce_ticks 10, output register empty
module pwm_motor_speed_direction_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [pmsd_pkg::CFG_W-1:0]      i_cfg_data,
    pmsd_in_if.sink                         i_in,
    pmsd_out_if.source                      o_out
);

    localparam logic [pmsd_pkg::DUTY_W:0] PERIOD_X =
        (pmsd_pkg::DUTY_W+1)'(pmsd_pkg::PERIOD);

    logic [pmsd_pkg::STEP_W-1:0]   r_duty_step;
    logic [pmsd_pkg::TICKS_W-1:0]  r_debounce_ticks;

    logic [pmsd_pkg::DUTY_W-1:0]   r_phase, n_phase;
    logic [pmsd_pkg::DUTY_W-1:0]   r_duty, n_duty;
    logic                          r_forward, n_forward;

    logic                          r_valid;
    logic                          r_drive_fwd, r_drive_rev, r_fwd_out;
    logic [pmsd_pkg::DUTY_W-1:0]   r_duty_out;

    logic                          accept;
    logic                          pwm;
    logic [pmsd_pkg::DUTY_W:0]     phase_inc;
    logic [pmsd_pkg::DUTY_W:0]     duty_sum;
    logic [pmsd_pkg::DUTY_W-1:0]   step_x;
    pmsd_pkg::t_keys               keys;
    pmsd_pkg::t_key_cmd            cmd;

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign keys.up_n      = i_in.key_up_n;
    assign keys.down_n    = i_in.key_down_n;
    assign keys.reverse_n = i_in.key_reverse_n;

    pmsd_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (accept),
        .i_keys           (keys),
        .i_debounce_ticks (r_debounce_ticks),
        .o_cmd            (cmd)
    );

    assign step_x   = {1'b0, r_duty_step};
    assign duty_sum = {1'b0, r_duty} + {2'b00, r_duty_step};

    always_comb begin
        n_duty    = r_duty;
        n_forward = r_forward;
        if (cmd.turn) begin
            n_forward = !r_forward;
        end
        if (cmd.up) begin
            n_duty = (duty_sum >= PERIOD_X) ? PERIOD_X[pmsd_pkg::DUTY_W-1:0]
                                            : duty_sum[pmsd_pkg::DUTY_W-1:0];
        end
        if (cmd.down) begin
            n_duty = (r_duty <= step_x) ? '0 : r_duty - step_x;
        end
    end

    assign phase_inc = {1'b0, r_phase} + 1'b1;
    assign pwm       = (phase_inc < {1'b0, n_duty});
    assign n_phase   = (phase_inc >= PERIOD_X) ? '0 : phase_inc[pmsd_pkg::DUTY_W-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_step      <= pmsd_pkg::STEP_RESET;
            r_debounce_ticks <= pmsd_pkg::TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmsd_pkg::CFG_DUTY_STEP:
                    r_duty_step <= i_cfg_data[pmsd_pkg::STEP_W-1:0];
                pmsd_pkg::CFG_DEBOUNCE_TICKS:
                    r_debounce_ticks <= i_cfg_data[pmsd_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_duty    <= pmsd_pkg::DUTY_RESET;
            r_forward <= 1'b1;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_duty    <= n_duty;
            r_forward <= n_forward;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive_fwd <= n_forward && pwm;
            r_drive_rev <= !n_forward && pwm;
            r_duty_out  <= n_duty;
            r_fwd_out   <= n_forward;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.drive_forward = r_drive_fwd;
    assign o_out.drive_reverse = r_drive_rev;
    assign o_out.duty_now      = r_duty_out;
    assign o_out.forward_now   = r_fwd_out;

endmodule

[sv/pmsd_checker.sv]
// checker on the top level ports, with its bind
`include "assert_macros.svh"

module pmsd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_drive_forward,
    input logic                          i_drive_reverse,
    input logic [pmsd_pkg::DUTY_W-1:0]   i_duty_now,
    input logic                          i_forward_now
);

    localparam logic [pmsd_pkg::DUTY_W-1:0] PERIOD_D =
        pmsd_pkg::DUTY_W'(pmsd_pkg::PERIOD);

    `PMSD_ASSERT_NOW(a_one_side, i_clk, i_rst_n, i_out_valid, !(i_drive_forward && i_drive_reverse), "both drive outputs high")
    `PMSD_ASSERT_NOW(a_drive_dir, i_clk, i_rst_n, i_out_valid, (i_forward_now || !i_drive_forward) && (!i_forward_now || !i_drive_reverse), "drive output against direction")
    `PMSD_ASSERT_NOW(a_duty_range, i_clk, i_rst_n, i_out_valid, i_duty_now <= PERIOD_D, "duty above period")
    `PMSD_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready, "transaction taken while result stalled")
    `PMSD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_duty_now), "stalled result changed")

endmodule

bind pwm_motor_speed_direction_top pmsd_checker u_pmsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_drive_forward (o_out.drive_forward),
    .i_drive_reverse (o_out.drive_reverse),
    .i_duty_now      (o_out.duty_now),
    .i_forward_now   (o_out.forward_now)
);

[test/tb.sv]
// testbench for the pwm motor speed and direction block: random key ticks checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_WAIT, SEQ_RELEASE} t_seq;
    typedef enum logic [1:0] {KEY_NONE, KEY_REV, KEY_UP, KEY_DOWN} t_key;

    typedef struct packed {
        logic                          drive_fwd;
        logic                          drive_rev;
        logic [pmsd_pkg::DUTY_W-1:0]   duty;
        logic                          fwd;
    } t_motor_out;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_idx = pmsd_pkg::CFG_DUTY_STEP;
    logic [pmsd_pkg::CFG_W-1:0]   cfg_data = '0;

    pmsd_in_if  in_if ();
    pmsd_out_if out_if ();

    pwm_motor_speed_direction_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predicted motor state and register copies
    logic [pmsd_pkg::DUTY_W-1:0]  m_phase;
    logic [pmsd_pkg::DUTY_W-1:0]  m_duty;
    logic                         m_fwd;
    t_seq                         m_seq;
    t_key                         m_key;
    logic [pmsd_pkg::TICKS_W-1:0] m_wait;
    logic [pmsd_pkg::STEP_W-1:0]  m_step;
    logic [pmsd_pkg::TICKS_W-1:0] m_ticks;

    pmsd_pkg::t_keys tick_q[$];
    t_motor_out      motor_out_q[$];
    int              send_gap_pct = 0;
    int              recv_stall_pct = 0;
    int              fail_count = 0;
    int              idle_cycles = 0;
    int              ticks_queued = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_pressed(t_key k, pmsd_pkg::t_keys keys);
        case (k)
            KEY_REV:  return !keys.reverse_n;
            KEY_UP:   return !keys.up_n;
            KEY_DOWN: return !keys.down_n;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic void apply_press(t_key k);
        int sum;
        if (k == KEY_REV) begin
            m_fwd = !m_fwd;
        end else if (k == KEY_UP) begin
            sum = int'(m_duty) + int'(m_step);
            m_duty = (sum >= pmsd_pkg::PERIOD) ? pmsd_pkg::DUTY_W'(pmsd_pkg::PERIOD)
                                               : pmsd_pkg::DUTY_W'(sum);
        end else if (k == KEY_DOWN) begin
            m_duty = (int'(m_duty) <= int'(m_step)) ? '0
                                                    : pmsd_pkg::DUTY_W'(m_duty - m_step);
        end
    endfunction

    function automatic void step_motor(pmsd_pkg::t_keys keys);
        int         nxt;
        logic       pwm;
        t_motor_out r;
        case (m_seq)
            SEQ_WAIT: begin
                if (m_wait != 0)
                    m_wait = m_wait - 1'b1;
                if (m_wait == 0) begin
                    if (is_pressed(m_key, keys))
                        apply_press(m_key);
                    m_seq = SEQ_RELEASE;
                end
            end
            SEQ_RELEASE: begin
                if (!is_pressed(m_key, keys)) begin
                    m_seq = SEQ_IDLE;
                    m_key = KEY_NONE;
                end
            end
            default: begin
                if (!keys.reverse_n)
                    m_key = KEY_REV;
                else if (!keys.up_n)
                    m_key = KEY_UP;
                else if (!keys.down_n)
                    m_key = KEY_DOWN;
                else
                    m_key = KEY_NONE;
                m_seq = SEQ_IDLE;
                if (m_key != KEY_NONE) begin
                    m_wait = m_ticks;
                    m_seq = SEQ_WAIT;
                end
            end
        endcase
        nxt = int'(m_phase) + 1;
        pwm = (nxt < int'(m_duty));
        m_phase = (nxt >= pmsd_pkg::PERIOD) ? '0 : pmsd_pkg::DUTY_W'(nxt);
        r.drive_fwd = m_fwd & pwm;
        r.drive_rev = !m_fwd & pwm;
        r.duty = m_duty;
        r.fwd = m_fwd;
        motor_out_q.push_back(r);
    endfunction

    // driver: one key tick per transaction
    always @(posedge i_clk) begin : drive
        pmsd_pkg::t_keys keys;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                keys.up_n = in_if.key_up_n;
                keys.down_n = in_if.key_down_n;
                keys.reverse_n = in_if.key_reverse_n;
                step_motor(keys);
            end
            if (!in_if.valid || in_if.ready) begin
                if (tick_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    keys = tick_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.key_up_n <= keys.up_n;
                    in_if.key_down_n <= keys.down_n;
                    in_if.key_reverse_n <= keys.reverse_n;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_motor_out exp_r;
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (motor_out_q.size() == 0) begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end else begin
                exp_r = motor_out_q.pop_front();
                check_field("drive_forward", exp_r.drive_fwd, out_if.drive_forward);
                check_field("drive_reverse", exp_r.drive_rev, out_if.drive_reverse);
                check_field("duty_now", exp_r.duty, out_if.duty_now);
                check_field("forward_now", exp_r.fwd, out_if.forward_now);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_tick(pmsd_pkg::t_keys t);
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    task automatic press_key(t_key k, int hold, int rel);
        pmsd_pkg::t_keys t;
        for (int i = 0; i < hold; i++) begin
            t = ($urandom_range(7) == 0) ? pmsd_pkg::t_keys'(3'($urandom_range(7)))
                                         : pmsd_pkg::t_keys'(3'b111);
            if (!(i < 2 && $urandom_range(3) == 0)) begin
                case (k)
                    KEY_REV: t.reverse_n = 1'b0;
                    KEY_UP:  t.up_n = 1'b0;
                    default: t.down_n = 1'b0;
                endcase
            end
            push_tick(t);
        end
        for (int i = 0; i < rel; i++) begin
            t = ($urandom_range(9) == 0) ? pmsd_pkg::t_keys'(3'($urandom_range(7)))
                                         : pmsd_pkg::t_keys'(3'b111);
            case (k)
                KEY_REV: t.reverse_n = 1'b1;
                KEY_UP:  t.up_n = 1'b1;
                default: t.down_n = 1'b1;
            endcase
            push_tick(t);
        end
    endtask

    task automatic run_random(int budget);
        int   start;
        int   settle;
        int   hold;
        t_key k;
        start = ticks_queued;
        while (ticks_queued - start < budget) begin
            if ($urandom_range(99) < 80) begin
                k = t_key'(2'($urandom_range(1, 3)));
                settle = (m_ticks == 0) ? 1 : int'(m_ticks);
                if ($urandom_range(1))
                    hold = settle + 1 + $urandom_range(3);
                else
                    hold = $urandom_range(1, settle + 1);
                press_key(k, hold, $urandom_range(1, 4));
            end else begin
                repeat ($urandom_range(1, 6))
                    push_tick(pmsd_pkg::t_keys'(3'($urandom_range(7))));
            end
        end
    endtask

    task automatic wait_quiet();
        while (tick_q.size() != 0 || motor_out_q.size() != 0 || in_if.valid)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [pmsd_pkg::CFG_W-1:0] d);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        if (idx == pmsd_pkg::CFG_DUTY_STEP)
            m_step = pmsd_pkg::STEP_W'(d);
        else
            m_ticks = d;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int gap_pct, int stall_pct);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic run_phase(int step, int ticks, int gap_pct, int stall_pct, int budget);
        wait_quiet();
        write_reg(pmsd_pkg::CFG_DUTY_STEP, pmsd_pkg::CFG_W'(step));
        write_reg(pmsd_pkg::CFG_DEBOUNCE_TICKS, pmsd_pkg::CFG_W'(ticks));
        set_idling(gap_pct, stall_pct);
        run_random(budget);
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.key_up_n = 1'b1;
        in_if.key_down_n = 1'b1;
        in_if.key_reverse_n = 1'b1;
        out_if.ready = 1'b0;
        m_phase = '0;
        m_duty = pmsd_pkg::DUTY_RESET;
        m_fwd = 1'b1;
        m_seq = SEQ_IDLE;
        m_key = KEY_NONE;
        m_wait = '0;
        m_step = pmsd_pkg::STEP_RESET;
        m_ticks = pmsd_pkg::TICKS_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all keys at once (turn wins), then a held increase
        push_tick(pmsd_pkg::t_keys'(3'b111));
        repeat (12) push_tick(pmsd_pkg::t_keys'(3'b000));
        push_tick(pmsd_pkg::t_keys'(3'b111));
        repeat (11) push_tick(pmsd_pkg::t_keys'(3'b011));

        // large step saturates both ways; sender stops midway until drained
        run_phase(50, 1, 82, 0, 200);
        wait_quiet();
        run_random(100);

        run_phase(0, 0, 0, 82, 200);
        run_phase(63, 3, 20, 20, 200);
        run_phase(1, 255, 0, 0, 400);
        run_phase(2, 2, 0, 0, 150);
        for (int i = 0; i < 3; i++)
            run_phase($urandom_range(1, 50), $urandom_range(1, 12),
                      (i == 1) ? 82 : 20, (i == 2) ? 82 : 20, 150);

        wait_quiet();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[pwm_motor_speed_direction_top.f]
+incdir+sv
sv/pmsd_pkg.sv
sv/pmsd_ifs.sv
sv/pmsd_debounce.sv
sv/pwm_motor_speed_direction_top.sv
sv/pmsd_checker.sv
test/tb.sv
